// ===== rtl/sdk_pkg.sv =====
// Shared constants, arithmetic tables and rounding helpers for the swerve drive
// kinematics block. No dependencies.

package sdk_pkg;

   localparam int MODULES        = 4;
   localparam int STEER_W        = 13;
   localparam int ENC_COUNTS     = 8192;
   localparam int SPEED_W        = 16;
   localparam int SPEED_MAX      = 21600;
   localparam int CORDIC_STEPS   = 16;
   localparam int ITER_W         = $clog2(CORDIC_STEPS);
   localparam int K_INV_Q16      = 39797;
   localparam int C0707_Q16      = 46334;
   localparam int CNT_SCALE      = 91;
   localparam int DATA_W         = 28;
   localparam int ANGLE_W        = 26;
   localparam int PROD_W         = 46;
   localparam int CSR_ADDR_W     = 3;

   typedef logic signed [DATA_W-1:0]  data_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   // Arctangent of 2^-i in degrees with 16 fraction bits.
   function automatic angle_type atan_q16(input logic [ITER_W-1:0] i);
      angle_type a;
      case (i)
         4'd0:    a = 26'sd2949120;
         4'd1:    a = 26'sd1740967;
         4'd2:    a = 26'sd919879;
         4'd3:    a = 26'sd466945;
         4'd4:    a = 26'sd234379;
         4'd5:    a = 26'sd117304;
         4'd6:    a = 26'sd58666;
         4'd7:    a = 26'sd29335;
         4'd8:    a = 26'sd14668;
         4'd9:    a = 26'sd7334;
         4'd10:   a = 26'sd3667;
         4'd11:   a = 26'sd1833;
         4'd12:   a = 26'sd917;
         4'd13:   a = 26'sd458;
         4'd14:   a = 26'sd229;
         4'd15:   a = 26'sd115;
         default: a = '0;
      endcase
      return a;
   endfunction

   // Shift right rounding to nearest, halves away from zero.
   function automatic prod_type round_shr(input prod_type v, input int s);
      prod_type half;
      prod_type r;
      half = prod_type'(1) <<< (s - 1);
      if (v >= 0) r = (v + half) >>> s;
      else r = -((-v + half) >>> s);
      return r;
   endfunction

endpackage

// ===== rtl/swerve_drive_kinematics.sv =====
// Top level of the four-module swerve drive inverse kinematics block.
// Depends on sdk_pkg for constants, the arctangent table and rounding.

// In move mode an item passes through the frame rotation, the gain and rate scaling
// and, for each module, vectoring and result scaling; a module whose wheel vector is
// zero skips its vectoring. In zero-force mode the result is presented in the cycle
// after acceptance. In either mode the result waits on rsp_tready; req_tready is low
// from acceptance until the result is taken.
// The single shared CORDIC stage runs 16 iterations for the frame rotation and 16
// for each module's vectoring, and the single multiplier does gain correction and
// angle scaling. Steering targets are encoder counts in [0, 8192); speeds are
// integer rpm saturated at 21600 before the reversal sign is applied.

module swerve_drive_kinematics (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vx_speed, vy_speed, vw_speed, heading_offset, steer_feedback, zero fill
   input  logic [71:0]  req_tdata,
   // mode, sticks_idle
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // wheel_speed_0..3, steer_target_0..3, reversed, zero fill
   output logic [119:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [sdk_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sdk_pkg::STEER_W-1:0]    csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_ROT, S_RX_MUL, S_RX_USE, S_RY_MUL, S_RY_USE, S_W_MUL, S_W_USE,
      S_VEC_LOAD, S_VEC, S_MAG_MUL, S_MAG_USE, S_CNT_MUL, S_CNT_USE, S_DECIDE, S_OUT
   } state_type;

   localparam int SW = sdk_pkg::STEER_W;
   localparam int HALF_TURN = sdk_pkg::ENC_COUNTS / 2;
   localparam int QUARTER_TURN = sdk_pkg::ENC_COUNTS / 4;

   state_type state_ff;
   logic [sdk_pkg::ITER_W-1:0] iter_ff;
   logic [1:0] mod_ff;
   sdk_pkg::data_type x_ff, y_ff, x_in, y_in;
   sdk_pkg::angle_type z_ff, z_in;
   sdk_pkg::data_type rx_ff, ry_ff, w_ff;
   logic signed [14:0] vw_ff;
   logic [SW-1:0] fb_ff;
   logic idle_ff;
   sdk_pkg::prod_type prod_ff, prod_in;
   sdk_pkg::data_type mul_a;
   logic [16:0] mul_b;
   logic [SW-1:0] offset_ff [sdk_pkg::MODULES];
   logic [SW-1:0] held_ff [sdk_pkg::MODULES];
   logic [SW-1:0] tgt_ff [sdk_pkg::MODULES];
   logic signed [sdk_pkg::SPEED_W-1:0] speed_ff [sdk_pkg::MODULES];
   logic dir_ff;

   // Heading reduction and frame rotation setup.
   logic signed [10:0] h;
   sdk_pkg::data_type lx, ly;
   sdk_pkg::angle_type lz;
   // Module vector setup.
   sdk_pkg::data_type va, vb;
   // Shared CORDIC stage.
   sdk_pkg::data_type dx, dy;
   sdk_pkg::angle_type at;
   // Result rounding.
   sdk_pkg::prod_type r16, r8, cnt;
   logic [SW-1:0] tgt_new;
   logic [SW-1:0] err, err_abs;
   logic flip;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign csr_ready = 1'b1;

   always_comb begin
      h = 11'(signed'(req_tdata[54:45]));
      if (h < 0) h = h + 11'sd360;
      if (h < 0) h = h + 11'sd360;
      if (h >= 11'sd360) h = h - 11'sd360;
      if (h > 11'sd180) h = h - 11'sd360;
      lx = sdk_pkg::data_type'(signed'(req_tdata[14:0])) <<< 8;
      ly = sdk_pkg::data_type'(signed'(req_tdata[29:15])) <<< 8;
      if (h > 11'sd90) begin
         lx = -lx;
         ly = -ly;
         h = h - 11'sd180;
      end else if (h < -11'sd90) begin
         lx = -lx;
         ly = -ly;
         h = h + 11'sd180;
      end
      lz = sdk_pkg::angle_type'(h) <<< 16;
   end

   always_comb begin
      va = (mod_ff < 2'd2) ? ry_ff - w_ff : ry_ff + w_ff;
      vb = (mod_ff == 2'd0 || mod_ff == 2'd3) ? rx_ff + w_ff : rx_ff - w_ff;
   end

   // One CORDIC iteration; rotation steers on z, vectoring on y.
   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      at = sdk_pkg::atan_q16(iter_ff);
      if ((state_ff == S_ROT) ? (z_ff >= 0) : (y_ff < 0)) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
      end
      if ((state_ff == S_ROT) ? (z_ff >= 0) : (y_ff < 0)) z_in = z_ff - at;
      else z_in = z_ff + at;
   end

   always_comb begin
      case (state_ff)
         S_RY_MUL: begin
            mul_a = y_ff;
            mul_b = 17'(sdk_pkg::K_INV_Q16);
         end
         S_W_MUL: begin
            mul_a = sdk_pkg::data_type'(vw_ff);
            mul_b = 17'(sdk_pkg::C0707_Q16);
         end
         S_CNT_MUL: begin
            mul_a = sdk_pkg::data_type'(z_ff);
            mul_b = 17'(sdk_pkg::CNT_SCALE);
         end
         default: begin
            mul_a = x_ff;
            mul_b = 17'(sdk_pkg::K_INV_Q16);
         end
      endcase
      prod_in = mul_a * $signed({1'b0, mul_b});
   end

   always_comb begin
      r16 = sdk_pkg::round_shr(prod_ff, 16);
      r8 = sdk_pkg::round_shr(prod_ff, 8);
      cnt = sdk_pkg::round_shr(prod_ff, 18);
      tgt_new = offset_ff[mod_ff] + SW'(cnt);
      err = fb_ff - tgt_ff[0];
      err_abs = err[SW-1] ? SW'(-err) : err;
      // An error beyond the half turn is folded by the full turn onto the shorter arc.
      if (32'(err_abs) > HALF_TURN) err_abs = SW'(sdk_pkg::ENC_COUNTS - 32'(err_abs));
      flip = (32'(err_abs) > QUARTER_TURN);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff <= S_IDLE;
         dir_ff <= 1'b0;
         iter_ff <= '0;
         mod_ff <= '0;
         for (int m = 0; m < sdk_pkg::MODULES; m++) begin
            offset_ff[m] <= '0;
            held_ff[m] <= '0;
         end
      end else begin
         if (csr_valid && csr_addr < sdk_pkg::CSR_ADDR_W'(sdk_pkg::MODULES))
            offset_ff[csr_addr[1:0]] <= csr_wdata;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  vw_ff <= signed'(req_tdata[44:30]);
                  fb_ff <= req_tdata[67:55];
                  idle_ff <= req_tuser[1];
                  x_ff <= lx;
                  y_ff <= ly;
                  z_ff <= lz;
                  iter_ff <= '0;
                  mod_ff <= '0;
                  if (req_tuser[0]) begin
                     for (int m = 0; m < sdk_pkg::MODULES; m++) begin
                        speed_ff[m] <= '0;
                        tgt_ff[m] <= held_ff[m];
                     end
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_ROT;
                  end
               end
            end
            S_ROT, S_VEC: begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= z_in;
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == sdk_pkg::ITER_W'(sdk_pkg::CORDIC_STEPS - 1))
                  state_ff <= (state_ff == S_ROT) ? S_RX_MUL : S_MAG_MUL;
            end
            S_RX_MUL: state_ff <= S_RX_USE;
            S_RX_USE: begin
               rx_ff <= sdk_pkg::DATA_W'(r16);
               state_ff <= S_RY_MUL;
            end
            S_RY_MUL: state_ff <= S_RY_USE;
            S_RY_USE: begin
               ry_ff <= sdk_pkg::DATA_W'(r16);
               state_ff <= S_W_MUL;
            end
            S_W_MUL: state_ff <= S_W_USE;
            S_W_USE: begin
               w_ff <= sdk_pkg::DATA_W'(r8);
               state_ff <= S_VEC_LOAD;
            end
            S_VEC_LOAD: begin
               iter_ff <= '0;
               if (va == 0 && vb == 0) begin
                  // A zero wheel vector has zero angle and zero speed.
                  x_ff <= '0;
                  y_ff <= '0;
                  z_ff <= '0;
                  state_ff <= S_MAG_MUL;
               end else if (vb < 0) begin
                  x_ff <= -vb;
                  y_ff <= -va;
                  z_ff <= (va >= 0) ? 26'sd11796480 : -26'sd11796480;
                  state_ff <= S_VEC;
               end else begin
                  x_ff <= vb;
                  y_ff <= va;
                  z_ff <= '0;
                  state_ff <= S_VEC;
               end
            end
            S_MAG_MUL: state_ff <= S_CNT_MUL;
            S_CNT_MUL: begin
               // prod_ff now holds the magnitude product.
               if (sdk_pkg::round_shr(r16, 8) > sdk_pkg::SPEED_MAX)
                  speed_ff[mod_ff] <= 16'(sdk_pkg::SPEED_MAX);
               else
                  speed_ff[mod_ff] <= 16'(sdk_pkg::round_shr(r16, 8));
               state_ff <= S_CNT_USE;
            end
            S_CNT_USE: begin
               tgt_ff[mod_ff] <= tgt_new;
               mod_ff <= mod_ff + 1'b1;
               state_ff <= (mod_ff == 2'd3) ? S_DECIDE : S_VEC_LOAD;
            end
            S_DECIDE: begin
               dir_ff <= flip;
               for (int m = 0; m < sdk_pkg::MODULES; m++) begin
                  if (flip) speed_ff[m] <= -speed_ff[m];
                  if (idle_ff) begin
                     tgt_ff[m] <= held_ff[m];
                  end else if (flip) begin
                     tgt_ff[m] <= tgt_ff[m] + SW'(HALF_TURN);
                     held_ff[m] <= tgt_ff[m] + SW'(HALF_TURN);
                  end else begin
                     held_ff[m] <= tgt_ff[m];
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {3'b000, dir_ff, tgt_ff[3], tgt_ff[2], tgt_ff[1], tgt_ff[0],
                       speed_ff[3], speed_ff[2], speed_ff[1], speed_ff[0]};

endmodule
